@@ hdl/resp_command_stream_parser_core_defines.svh @@
// Assertion helpers for the request parser core.
// Both expect a clock named clk and an active-low reset named rst_n in scope.
`ifndef RESP_COMMAND_STREAM_PARSER_CORE_DEFINES_SVH
`define RESP_COMMAND_STREAM_PARSER_CORE_DEFINES_SVH

// Consequent holds in the same cycle as the antecedent.
`define RCSP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rcsp: same-cycle check failed");

// Consequent holds in the cycle after the antecedent.
`define RCSP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rcsp: next-cycle check failed");

`endif

@@ hdl/rcsp_pkg.sv @@
`default_nettype none
package rcsp_pkg;

  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  typedef enum logic [8:0] {
    PH_START  = 9'b000000001,
    PH_COUNT  = 9'b000000010,
    PH_SEEK   = 9'b000000100,
    PH_LEN    = 9'b000001000,
    PH_SKIP1  = 9'b000010000,
    PH_DATA   = 9'b000100000,
    PH_SKIP2  = 9'b001000000,
    PH_INLINE = 9'b010000000,
    PH_ERROR  = 9'b100000000
  } phase_t;

  typedef enum logic [1:0] {
    NUM_DIGIT = 2'd0,
    NUM_END   = 2'd1,
    NUM_ERR   = 2'd2
  } num_status_t;

  typedef struct packed {
    logic [7:0] arg_byte;
    logic       has_byte;
    logic       arg_end;
    logic       cmd_end;
    logic       parse_error;
  } result_t;

endpackage
`default_nettype wire

@@ hdl/rcsp_num.sv @@
`default_nettype none
module rcsp_num #(
  parameter int NUMBER_WIDTH = 32
) (
  input  wire logic [7:0]              num_byte,
  input  wire logic [NUMBER_WIDTH-1:0] num_accum,
  input  wire logic                    num_seen,
  output rcsp_pkg::num_status_t        num_status,
  output logic [NUMBER_WIDTH-1:0]      num_next
);

  localparam int WideW = NUMBER_WIDTH + 4;

  logic             is_digit;
  logic [3:0]       digit;
  logic [WideW-1:0] wide;
  logic             ovf;

  assign is_digit = (num_byte >= rcsp_pkg::CH_ZERO) && (num_byte <= rcsp_pkg::CH_NINE);
  assign digit    = 4'(num_byte - rcsp_pkg::CH_ZERO);

  // accum * 10 + digit, four spare bits catch any overflow of the number width
  assign wide = ({4'b0, num_accum} << 3) + ({4'b0, num_accum} << 1)
              + {{NUMBER_WIDTH{1'b0}}, digit};
  assign ovf      = |wide[WideW-1:NUMBER_WIDTH];
  assign num_next = wide[NUMBER_WIDTH-1:0];

  always_comb begin
    if (num_byte == rcsp_pkg::CH_CR) begin
      num_status = num_seen ? rcsp_pkg::NUM_END : rcsp_pkg::NUM_ERR;
    end else if (!is_digit || ovf) begin
      num_status = rcsp_pkg::NUM_ERR;
    end else begin
      num_status = rcsp_pkg::NUM_DIGIT;
    end
  end

endmodule
`default_nettype wire

@@ hdl/rcsp_fsm.sv @@
`default_nettype none
module rcsp_fsm #(
  parameter int NUMBER_WIDTH = 32
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step_en,
  input  wire logic [7:0] step_byte,
  output rcsp_pkg::result_t res,
  output logic            res_any,
  output logic            in_error
);

  rcsp_pkg::phase_t phase_r, phase_nxt;
  logic [NUMBER_WIDTH-1:0] accum_r, accum_nxt;
  logic                    seen_r, seen_nxt;
  logic [NUMBER_WIDTH-1:0] args_r, args_nxt;
  logic [NUMBER_WIDTH-1:0] bytes_r, bytes_nxt;
  logic [7:0]              held_r, held_nxt;

  rcsp_pkg::num_status_t   num_status;
  logic [NUMBER_WIDTH-1:0] num_next;
  rcsp_pkg::result_t       res_raw;

  rcsp_num #(.NUMBER_WIDTH(NUMBER_WIDTH)) u_num (
    .num_byte   (step_byte),
    .num_accum  (accum_r),
    .num_seen   (seen_r),
    .num_status (num_status),
    .num_next   (num_next)
  );

  always_comb begin
    phase_nxt = phase_r;
    accum_nxt = accum_r;
    seen_nxt  = seen_r;
    args_nxt  = args_r;
    bytes_nxt = bytes_r;
    held_nxt  = held_r;
    res_raw   = '0;
    case (phase_r)
      rcsp_pkg::PH_START: begin
        if (step_byte == rcsp_pkg::CH_STAR) begin
          accum_nxt = '0;
          seen_nxt  = 1'b0;
          phase_nxt = rcsp_pkg::PH_COUNT;
        end else if (step_byte == rcsp_pkg::CH_LF) begin
          res_raw.arg_end = 1'b1;
          res_raw.cmd_end = 1'b1;
        end else begin
          held_nxt  = step_byte;
          phase_nxt = rcsp_pkg::PH_INLINE;
        end
      end
      rcsp_pkg::PH_INLINE: begin
        // the held byte is always live here; the one before LF is dropped
        if (step_byte == rcsp_pkg::CH_LF) begin
          res_raw.arg_end = 1'b1;
          res_raw.cmd_end = 1'b1;
          phase_nxt       = rcsp_pkg::PH_START;
        end else begin
          res_raw.arg_byte = held_r;
          res_raw.has_byte = 1'b1;
          held_nxt         = step_byte;
        end
      end
      rcsp_pkg::PH_COUNT: begin
        case (num_status)
          rcsp_pkg::NUM_DIGIT: begin
            accum_nxt = num_next;
            seen_nxt  = 1'b1;
          end
          rcsp_pkg::NUM_END: begin
            if (accum_r == '0) begin
              // empty command; its CR opens an inline line
              res_raw.cmd_end = 1'b1;
              held_nxt        = step_byte;
              phase_nxt       = rcsp_pkg::PH_INLINE;
            end else begin
              args_nxt  = accum_r;
              phase_nxt = rcsp_pkg::PH_SEEK;
            end
            accum_nxt = '0;
            seen_nxt  = 1'b0;
          end
          default: phase_nxt = rcsp_pkg::PH_ERROR;
        endcase
      end
      rcsp_pkg::PH_SEEK: begin
        if (step_byte == rcsp_pkg::CH_DOLLAR) begin
          accum_nxt = '0;
          seen_nxt  = 1'b0;
          phase_nxt = rcsp_pkg::PH_LEN;
        end
      end
      rcsp_pkg::PH_LEN: begin
        case (num_status)
          rcsp_pkg::NUM_DIGIT: begin
            accum_nxt = num_next;
            seen_nxt  = 1'b1;
          end
          rcsp_pkg::NUM_END: begin
            bytes_nxt = accum_r;
            accum_nxt = '0;
            seen_nxt  = 1'b0;
            phase_nxt = rcsp_pkg::PH_SKIP1;
          end
          default: phase_nxt = rcsp_pkg::PH_ERROR;
        endcase
      end
      rcsp_pkg::PH_SKIP1: begin
        if (step_byte == rcsp_pkg::CH_LF) begin
          phase_nxt = (bytes_r == '0) ? rcsp_pkg::PH_SKIP2 : rcsp_pkg::PH_DATA;
        end
      end
      rcsp_pkg::PH_DATA: begin
        res_raw.arg_byte = step_byte;
        res_raw.has_byte = 1'b1;
        bytes_nxt        = bytes_r - NUMBER_WIDTH'(1);
        if (bytes_r == NUMBER_WIDTH'(1)) begin
          phase_nxt = rcsp_pkg::PH_SKIP2;
        end
      end
      rcsp_pkg::PH_SKIP2: begin
        if (step_byte == rcsp_pkg::CH_LF) begin
          res_raw.arg_end = 1'b1;
          args_nxt        = args_r - NUMBER_WIDTH'(1);
          if (args_r == NUMBER_WIDTH'(1)) begin
            res_raw.cmd_end = 1'b1;
            phase_nxt       = rcsp_pkg::PH_START;
          end else begin
            phase_nxt = rcsp_pkg::PH_SEEK;
          end
        end
      end
      default: phase_nxt = rcsp_pkg::PH_ERROR;
    endcase
  end

  // error is sticky and masks every other field
  always_comb begin
    if (phase_nxt == rcsp_pkg::PH_ERROR) begin
      res             = '0;
      res.parse_error = 1'b1;
    end else begin
      res = res_raw;
    end
  end

  assign res_any  = res.has_byte | res.arg_end | res.cmd_end | res.parse_error;
  assign in_error = (phase_r == rcsp_pkg::PH_ERROR);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= rcsp_pkg::PH_START;
      accum_r <= '0;
      seen_r  <= 1'b0;
      args_r  <= '0;
      bytes_r <= '0;
      held_r  <= '0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      accum_r <= accum_nxt;
      seen_r  <= seen_nxt;
      args_r  <= args_nxt;
      bytes_r <= bytes_nxt;
      held_r  <= held_nxt;
    end
  end

endmodule
`default_nettype wire

@@ hdl/resp_command_stream_parser_core.sv @@
// Request stream parser: one request byte in, at most one result out.
// Path: an accepted byte is registered, then stepped through the parser into
// the result register if it yields one; inline line bytes come out one byte late.
// Throughput: one byte per cycle, stalled while a held result waits for out_ready.
// Reset (rst_n low, synchronous): parser returns to command start, counters
// and the sticky error clear, input and result registers empty.
`default_nettype none
`include "resp_command_stream_parser_core_defines.svh"
module resp_command_stream_parser_core #(
  parameter int NUMBER_WIDTH = 32
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_arg_byte,
  output logic            out_has_byte,
  output logic            out_arg_end,
  output logic            out_cmd_end,
  output logic            out_parse_error
);

  logic              s1_valid_r, s1_valid_nxt;
  logic [7:0]        s1_byte_r;
  logic              out_valid_r, out_valid_nxt;
  rcsp_pkg::result_t out_res_r;
  logic              out_free;
  logic              s1_advance;
  logic              in_xfer;
  rcsp_pkg::result_t res;
  logic              res_any;
  logic              in_error;
  logic              out_marks;

  assign out_free   = !out_valid_r || out_ready;
  assign s1_advance = s1_valid_r && out_free;
  assign in_ready   = !s1_valid_r || out_free;
  assign in_xfer    = in_valid && in_ready;

  rcsp_fsm #(.NUMBER_WIDTH(NUMBER_WIDTH)) u_fsm (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (s1_advance),
    .step_byte (s1_byte_r),
    .res       (res),
    .res_any   (res_any),
    .in_error  (in_error)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_advance && res_any) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload: hold the byte and the result until the next transfer
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_byte_r <= in_byte;
    end
    if (s1_advance && res_any) begin
      out_res_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_arg_byte    = out_res_r.arg_byte;
  assign out_has_byte    = out_res_r.has_byte;
  assign out_arg_end     = out_res_r.arg_end;
  assign out_cmd_end     = out_res_r.cmd_end;
  assign out_parse_error = out_res_r.parse_error;

  assign out_marks = out_res_r.arg_end | out_res_r.cmd_end | out_res_r.parse_error;

  `RCSP_ASSERT_NEXT(a_error_sticky, in_error, in_error)
  `RCSP_ASSERT_NOW(a_data_alone, out_valid_r && out_res_r.has_byte, !out_marks)
  `RCSP_ASSERT_NEXT(a_stage_hold, s1_valid_r && !out_free, s1_valid_r && $stable(s1_byte_r))

endmodule
`default_nettype wire
